@@ sv/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg: shared types and codes of the list edit engine
// Command codes, status codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

  localparam logic [3:0] CMD_APPEND     = 4'd0;
  localparam logic [3:0] CMD_DROP_LAST  = 4'd1;
  localparam logic [3:0] CMD_DELETE_AT  = 4'd2;
  localparam logic [3:0] CMD_DELETE_MIN = 4'd3;
  localparam logic [3:0] CMD_REVERSE    = 4'd4;
  localparam logic [3:0] CMD_REMOVE_EQ  = 4'd5;
  localparam logic [3:0] CMD_OPEN_RANGE = 4'd6;
  localparam logic [3:0] CMD_CLOSED_RNG = 4'd7;
  localparam logic [3:0] CMD_DEDUPE     = 4'd8;
  localparam logic [3:0] CMD_READ_ALL   = 4'd9;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_ORDER  = 3'd4
  } status_t;

  typedef struct packed {
    logic    accept;
    logic    drop;
    logic    append;
    logic    scan_clr;
    logic    scan_run;
    logic    min_run;
    logic    min_take;
    logic    cp_done;
    logic    rev_init;
    logic    rev_ra;
    logic    rev_rb;
    logic    rev_wa;
    logic    rev_wb;
    logic    rd_init;
    logic    rd_issue;
    logic    rd_emit;
    logic    res_load;
    status_t res_status;
  } ale_cmd_t;

  typedef struct packed {
    logic in_empty;
    logic in_full;
    logic in_pos_bad;
    logic in_order_bad;
    logic scan_done;
    logic rev_more;
    logic rd_last;
    logic out_free;
  } ale_stat_t;

endpackage

`default_nettype wire

@@ sv/array_list_edit_engine_top.sv @@
// ----------------------------------------------------------------------------
// array_list_edit_engine_top: packed list edit engine
// Packed list of signed 32-bit values with append, drop, delete, minimum
// removal, reverse, filtered removal, dedupe and read-out commands.
// ----------------------------------------------------------------------------
// One command word is taken at a time and every command returns at least one
// result word; read all returns one word per element. Append writes the new
// element before its result word; drop, unknown commands and the error cases
// go straight to the result word. Removal commands walk the store once through
// its single read port; delete minimum walks it twice, first to find the
// minimum and then to remove it. Reverse reads and then writes both elements
// of each swapped pair, read all reads each element before it emits it, and
// output stalls hold the result words. The output register lets a new command
// be taken while the last result word waits.
`default_nettype none

module array_list_edit_engine_top #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         command,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] upper_bound,
  input  wire logic [4:0]         position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic signed [31:0]      data_out,
  output logic [5:0]              length,
  output logic                    last
);

  ale_pkg::ale_cmd_t  cmd;
  ale_pkg::ale_stat_t stat;

  ale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  ale_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .command     (command),
    .value       (value),
    .upper_bound (upper_bound),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data_out    (data_out),
    .length      (length),
    .last        (last)
  );

endmodule

`default_nettype wire

@@ sv/ale_ram.sv @@
// ----------------------------------------------------------------------------
// ale_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ale_dp.sv @@
// ----------------------------------------------------------------------------
// ale_dp: list edit engine datapath
// Element store, count, scan pointers, minimum tracking, reverse swap and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_dp #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int SW = (AW > 5) ? AW : 5,
  localparam int PW = (CW > 5) ? CW : 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ale_pkg::ale_cmd_t   cmd,
  output ale_pkg::ale_stat_t       stat,
  input  wire logic [3:0]          command,
  input  wire logic signed [31:0]  value,
  input  wire logic signed [31:0]  upper_bound,
  input  wire logic [4:0]          position,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic signed [31:0]       data_out,
  output logic [5:0]               length,
  output logic                     last
);

  logic [CW-1:0]        count;
  logic [3:0]           cmd_q;
  logic signed [31:0]   lo;
  logic signed [31:0]   hi;
  logic [SW-1:0]        skip;
  logic [CW-1:0]        r;
  logic [CW-1:0]        w;
  logic                 v1;
  logic [AW-1:0]        r1;
  logic signed [31:0]   prev;
  logic signed [31:0]   bestv;
  logic signed [31:0]   res_data;
  logic [AW-1:0]        a;
  logic [AW-1:0]        b;
  logic signed [31:0]   da;
  logic [CW-1:0]        i;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [31:0]          wdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [31:0]          rdata_raw;
  logic signed [31:0]   rdata;
  logic                 issue;
  logic                 doomed;
  logic                 keep;

  assign rdata = $signed(rdata_raw);
  assign issue = (cmd.scan_run || cmd.min_run) && (r < count);

  always_comb begin
    case (cmd_q)
      ale_pkg::CMD_REMOVE_EQ:  doomed = (rdata == lo);
      ale_pkg::CMD_OPEN_RANGE: doomed = (lo < rdata) && (rdata < hi);
      ale_pkg::CMD_CLOSED_RNG: doomed = !(rdata < lo) && !(hi < rdata);
      ale_pkg::CMD_DEDUPE:     doomed = (w != '0) && (rdata == prev);
      default:                 doomed = (SW'(r1) == skip);
    endcase
  end

  assign keep = cmd.scan_run && v1 && !doomed;

  always_comb begin
    we    = 1'b0;
    waddr = w[AW-1:0];
    wdata = rdata_raw;
    re    = 1'b0;
    raddr = r[AW-1:0];
    if (cmd.append) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = lo;
    end else if (keep) begin
      we = 1'b1;
    end else if (cmd.rev_wa) begin
      we    = 1'b1;
      waddr = a;
    end else if (cmd.rev_wb) begin
      we    = 1'b1;
      waddr = b;
      wdata = da;
    end
    if (issue) begin
      re = 1'b1;
    end else if (cmd.rev_ra) begin
      re    = 1'b1;
      raddr = a;
    end else if (cmd.rev_rb) begin
      re    = 1'b1;
      raddr = b;
    end else if (cmd.rd_issue) begin
      re    = 1'b1;
      raddr = i[AW-1:0];
    end
  end

  ale_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1    <= 1'b0;
    end else begin
      if (cmd.drop) begin
        count <= count - CW'(1);
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.cp_done) begin
        count <= w;
      end
      if (cmd.scan_clr) begin
        v1 <= 1'b0;
      end else if (cmd.scan_run || cmd.min_run) begin
        v1 <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q    <= command;
      lo       <= value;
      hi       <= upper_bound;
      skip     <= SW'(position);
      res_data <= '0;
    end
    if (cmd.scan_clr) begin
      r <= '0;
      w <= '0;
    end else if (cmd.scan_run || cmd.min_run) begin
      if (issue) begin
        r <= r + CW'(1);
      end
      r1 <= r[AW-1:0];
    end
    if (keep) begin
      w    <= w + CW'(1);
      prev <= rdata;
    end
    if (cmd.min_run && v1 && ((r1 == '0) || (rdata < bestv))) begin
      bestv <= rdata;
      skip  <= SW'(r1);
    end
    if (cmd.min_take) begin
      res_data <= bestv;
    end
    if (cmd.rev_init) begin
      a <= '0;
      b <= AW'(count - CW'(1));
    end
    if (cmd.rev_rb) begin
      da <= rdata;
    end
    if (cmd.rev_wb) begin
      a <= a + AW'(1);
      b <= b - AW'(1);
    end
    if (cmd.rd_init) begin
      i <= '0;
    end else if (cmd.rd_emit) begin
      i <= i + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load || cmd.rd_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status   <= cmd.res_status;
      data_out <= res_data;
      length   <= 6'(count);
      last     <= 1'b1;
    end else if (cmd.rd_emit) begin
      status   <= ale_pkg::ST_OK;
      data_out <= rdata;
      length   <= 6'(count);
      last     <= stat.rd_last;
    end
  end

  always_comb begin
    stat.in_empty     = (count == '0);
    stat.in_full      = (count == CW'(DEPTH));
    stat.in_pos_bad   = (PW'(position) >= PW'(count));
    stat.in_order_bad = (upper_bound < value);
    stat.scan_done    = !(r < count) && !v1;
    stat.rev_more     = (a < b);
    stat.rd_last      = ((i + CW'(1)) == count);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

@@ sv/ale_ctrl.sv @@
// ----------------------------------------------------------------------------
// ale_ctrl: list edit engine controller
// State machine that takes a command word, sequences the datapath through
// the store walk it needs and hands over the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         command,
  input  wire ale_pkg::ale_stat_t stat,
  output ale_pkg::ale_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_APPEND  = 11'b00000000010,
    S_COMPACT = 11'b00000000100,
    S_MINSCAN = 11'b00000001000,
    S_REV_RA  = 11'b00000010000,
    S_REV_RB  = 11'b00000100000,
    S_REV_WA  = 11'b00001000000,
    S_REV_WB  = 11'b00010000000,
    S_RD_ISS  = 11'b00100000000,
    S_RD_EMIT = 11'b01000000000,
    S_RESULT  = 11'b10000000000
  } state_t;

  state_t            state;
  state_t            state_next;
  ale_pkg::status_t  st;
  ale_pkg::status_t  st_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    st_next        = st;
    cmd            = '0;
    cmd.res_status = st;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_next    = ale_pkg::ST_OK;
          state_next = S_RESULT;
          case (command)
            ale_pkg::CMD_APPEND: begin
              if (stat.in_full) st_next = ale_pkg::ST_FULL;
              else state_next = S_APPEND;
            end
            ale_pkg::CMD_DROP_LAST: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else cmd.drop = 1'b1;
            end
            ale_pkg::CMD_DELETE_AT: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else if (stat.in_pos_bad) st_next = ale_pkg::ST_BADPOS;
              else begin
                cmd.scan_clr = 1'b1;
                state_next   = S_COMPACT;
              end
            end
            ale_pkg::CMD_DELETE_MIN: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else begin
                cmd.scan_clr = 1'b1;
                state_next   = S_MINSCAN;
              end
            end
            ale_pkg::CMD_REVERSE: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else begin
                cmd.rev_init = 1'b1;
                state_next   = S_REV_RA;
              end
            end
            ale_pkg::CMD_REMOVE_EQ: begin
              cmd.scan_clr = 1'b1;
              state_next   = S_COMPACT;
            end
            ale_pkg::CMD_OPEN_RANGE, ale_pkg::CMD_CLOSED_RNG: begin
              if (stat.in_order_bad) st_next = ale_pkg::ST_ORDER;
              else if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else begin
                cmd.scan_clr = 1'b1;
                state_next   = S_COMPACT;
              end
            end
            ale_pkg::CMD_DEDUPE: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else begin
                cmd.scan_clr = 1'b1;
                state_next   = S_COMPACT;
              end
            end
            ale_pkg::CMD_READ_ALL: begin
              if (stat.in_empty) st_next = ale_pkg::ST_EMPTY;
              else begin
                cmd.rd_init = 1'b1;
                state_next  = S_RD_ISS;
              end
            end
            default: begin
              st_next = ale_pkg::ST_OK;
            end
          endcase
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_RESULT;
      end
      S_COMPACT: begin
        if (stat.scan_done) begin
          cmd.cp_done = 1'b1;
          state_next  = S_RESULT;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_MINSCAN: begin
        if (stat.scan_done) begin
          cmd.min_take = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_COMPACT;
        end else begin
          cmd.min_run = 1'b1;
        end
      end
      S_REV_RA: begin
        if (stat.rev_more) begin
          cmd.rev_ra = 1'b1;
          state_next = S_REV_RB;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_REV_RB: begin
        cmd.rev_rb = 1'b1;
        state_next = S_REV_WA;
      end
      S_REV_WA: begin
        cmd.rev_wa = 1'b1;
        state_next = S_REV_WB;
      end
      S_REV_WB: begin
        cmd.rev_wb = 1'b1;
        state_next = S_REV_RA;
      end
      S_RD_ISS: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next  = stat.rd_last ? S_IDLE : S_RD_ISS;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ale_pkg::ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

endmodule

`default_nettype wire
